@@ sv/bru_pkg.sv @@
// ----------------------------------------------------------------------------
// bru_pkg: shared types and constants of the BMP raster unpacker
// Beat payloads, pixel mode codes, register indexes and size limits.
// ----------------------------------------------------------------------------
package bru_pkg;

	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;
	localparam int PAL_DEPTH  = 256;
	localparam int PAL_AW     = $clog2(PAL_DEPTH);

	localparam int DIM_W      = 13;  // image_width / image_height registers
	localparam int COORD_W    = 12;  // column / row
	localparam int RBC_W      = 14;  // byte position within a row
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam int RGB_W      = 24;

	localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

	localparam logic KIND_PALETTE = 1'b0;
	localparam logic KIND_DATA    = 1'b1;

	typedef enum logic [1:0] {
		MODE_MONO  = 2'd0,
		MODE_PAL4  = 2'd1,
		MODE_PAL8  = 2'd2,
		MODE_BGR24 = 2'd3
	} mode_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
		logic [7:0] palette_index;
		logic [7:0] palette_red;
		logic [7:0] palette_green;
		logic [7:0] palette_blue;
	} raster_beat_t;

	typedef struct packed {
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
		logic [COORD_W-1:0] column;
		logic [COORD_W-1:0] row;
		logic               last_of_run;
		logic               last_of_image;
	} pixel_beat_t;

endpackage

@@ sv/bru_in_if.sv @@
// ----------------------------------------------------------------------------
// bru_in_if: raster input channel
// Valid/ready channel carrying raster bytes and palette entry writes.
// ----------------------------------------------------------------------------
interface bru_in_if;
	logic                  valid;
	logic                  ready;
	bru_pkg::raster_beat_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ sv/bru_out_if.sv @@
// ----------------------------------------------------------------------------
// bru_out_if: pixel output channel
// Valid/ready channel carrying decoded pixels with their position.
// ----------------------------------------------------------------------------
interface bru_out_if;
	logic                 valid;
	logic                 ready;
	bru_pkg::pixel_beat_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ sv/bru_ram.sv @@
// ----------------------------------------------------------------------------
// bru_ram: generic single-write, single-read RAM
// One write port, one read port with registered, enabled read data.
// ----------------------------------------------------------------------------
module bru_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ sv/bmp_raster_unpacker.sv @@
// ----------------------------------------------------------------------------
// bmp_raster_unpacker: BMP raster bytes to tagged RGB pixels
// Decodes 1 bpp mono, 4/8 bpp palette and 24 bpp BGR rows, bottom-up.
// ----------------------------------------------------------------------------
// Usage:
//   raster: one beat per byte of the pixel array (kind = data) or per palette
//     entry (kind = palette). Load the palette before the raster bytes that
//     use it. Row padding bytes are consumed and give no pixels.
//   pixel: one beat per pixel with its top-down row and column, last_of_run
//     on the final pixel of a byte, last_of_image on the final image pixel.
//   wr_en/wr_index/wr_data: pixel mode, width, height; write only while idle.
//     A write to one of these three registers restarts the raster position, the palette is kept.
// Pipeline: an accepted byte passes the byte stage, then the output stage
//   that also holds the palette read.
// Throughput: one raster beat per cycle while a byte yields at most one pixel
//   and pixel.ready is high. A byte that yields n pixels (up to 8 at 1 bpp,
//   2 at 4 bpp) holds the byte stage until all n are out, since the output carries one pixel per beat.
// Stall: when pixel.ready is low the output stage holds, the byte stage holds
//   its remaining pixels and raster.ready drops once it has work left.
// Reset: counters clear, mode 24 bpp, width and height 1; palette contents
//   are undefined until written.
// ----------------------------------------------------------------------------
module bmp_raster_unpacker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [bru_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [bru_pkg::CFG_DATA_W-1:0]   wr_data,
	bru_in_if.sink                           raster,
	bru_out_if.source                        pixel
);
	import bru_pkg::*;

	// clamp a dimension: zero counts as one, large values saturate
	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
		input logic [DIM_W-1:0] maxv);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > maxv) begin
			r = maxv;
		end
		return r;
	endfunction

	// bytes of pixel data in one row, before padding
	function automatic logic [RBC_W-1:0] row_bytes(input mode_t m,
		input logic [DIM_W-1:0] w);
		logic [RBC_W-1:0] w14;
		logic [RBC_W-1:0] r;
		w14 = RBC_W'(w);
		case (m)
			MODE_MONO: r = (w14 + RBC_W'(7)) >> 3;
			MODE_PAL4: r = (w14 + RBC_W'(1)) >> 1;
			MODE_PAL8: r = w14;
			default:   r = (w14 << 1) + w14;
		endcase
		return r;
	endfunction

	// ---------------- configuration ----------------
	mode_t              mode_q;
	logic [DIM_W-1:0]   width_q;     // already clamped
	logic [DIM_W-1:0]   height_q;    // already clamped
	logic [RBC_W-1:0]   data_bytes_q;
	logic [RBC_W-1:0]   stride_q;

	mode_t              mode_nx;
	logic [DIM_W-1:0]   width_nx;
	logic [DIM_W-1:0]   height_nx;
	logic [RBC_W-1:0]   data_bytes_nx;
	logic               cfg_hit;

	always_comb begin
		mode_nx   = mode_q;
		width_nx  = width_q;
		height_nx = height_q;
		cfg_hit   = 1'b0;
		if (wr_en) begin
			case (wr_index)
				CFG_PIXEL_MODE: begin
					mode_nx = mode_t'(wr_data[1:0]);
					cfg_hit = 1'b1;
				end
				CFG_IMAGE_WIDTH: begin
					width_nx = eff_dim(wr_data, DIM_W'(MAX_WIDTH));
					cfg_hit  = 1'b1;
				end
				CFG_IMAGE_HEIGHT: begin
					height_nx = eff_dim(wr_data, DIM_W'(MAX_HEIGHT));
					cfg_hit   = 1'b1;
				end
				default: ;
			endcase
		end
		data_bytes_nx = row_bytes(mode_nx, width_nx);
	end

	// width - 1 and height - 1 as coordinates (4096 wraps to 4095)
	logic [COORD_W-1:0] w_last;
	logic [COORD_W-1:0] h_last;
	assign w_last = width_q[COORD_W-1:0] - COORD_W'(1);
	assign h_last = height_q[COORD_W-1:0] - COORD_W'(1);

	// ---------------- raster position ----------------
	logic [RBC_W-1:0]   rbc_q;        // byte position in the current row
	logic [COORD_W-1:0] col_q;
	logic [COORD_W-1:0] rows_done_q;
	logic [15:0]        gathered_q;   // B in [7:0], G in [15:8]
	logic [1:0]         phase_q;

	raster_beat_t       ib;
	logic               in_acc;
	logic               is_data;
	logic               in_row;
	logic [16:0]        mono_left;
	logic [3:0]         mono_cnt;
	logic               pal4_two;
	logic [3:0]         n_pix;
	logic [RBC_W-1:0]   rbc_inc;
	logic               row_end;
	logic [15:0]        gathered_nx;
	logic [1:0]         phase_nx;

	assign ib      = raster.data;
	assign in_acc  = raster.valid && raster.ready;
	assign is_data = (ib.kind == KIND_DATA);
	assign in_row  = (rbc_q < data_bytes_q);

	assign mono_left = {4'b0, width_q} - {rbc_q, 3'b000};
	assign mono_cnt  = (mono_left >= 17'd8) ? 4'd8 : mono_left[3:0];
	assign pal4_two  = ({rbc_q, 1'b1} < {2'b00, width_q});
	assign rbc_inc   = rbc_q + RBC_W'(1);
	assign row_end   = (rbc_inc >= stride_q);

	always_comb begin
		n_pix       = 4'd0;
		gathered_nx = gathered_q;
		phase_nx    = phase_q;
		if (in_row) begin
			case (mode_q)
				MODE_MONO: n_pix = mono_cnt;
				MODE_PAL4: n_pix = pal4_two ? 4'd2 : 4'd1;
				MODE_PAL8: n_pix = 4'd1;
				default: begin
					// gather B then G; the R byte completes the pixel
					if (phase_q < 2'd2) begin
						gathered_nx = gathered_q | ({8'h00, ib.data_byte} << {phase_q, 3'b000});
						phase_nx    = phase_q + 2'd1;
					end else begin
						gathered_nx = '0;
						phase_nx    = '0;
						n_pix       = 4'd1;
					end
				end
			endcase
		end
	end

	// ---------------- byte stage ----------------
	logic               valid_s1;
	logic               pal_s1;      // palette entry write pending
	logic [3:0]         left_s1;     // pixels still to issue
	mode_t              mode_s1;
	logic [7:0]         byte_s1;
	logic [RGB_W-1:0]   rgb_s1;
	logic [7:0]         idx_s1;
	logic [COORD_W-1:0] col_s1;
	logic [COORD_W-1:0] row_s1;
	logic               top_s1;

	// ---------------- output stage ----------------
	logic               valid_s2;
	logic               pal_s2;
	logic               black_s2;
	logic [RGB_W-1:0]   rgb_s2;
	logic [COORD_W-1:0] col_s2;
	logic [COORD_W-1:0] row_s2;
	logic               lor_s2;
	logic               loi_s2;

	logic               s2_free;
	logic               emit;
	logic               s1_done;
	logic               use_pal;
	logic [7:0]         rd_idx;
	logic [RGB_W-1:0]   direct_rgb;
	logic               pal_we;
	logic [RGB_W-1:0]   pal_rdata;

	assign s2_free = !valid_s2 || pixel.ready;
	assign emit    = valid_s1 && !pal_s1 && (left_s1 != 4'd0) && s2_free;
	assign s1_done = valid_s1 && (pal_s1 || (left_s1 == 4'd0) ||
		((left_s1 == 4'd1) && s2_free));
	assign raster.ready = !valid_s1 || s1_done;

	assign use_pal    = (mode_s1 == MODE_PAL4) || (mode_s1 == MODE_PAL8);
	assign rd_idx     = (mode_s1 == MODE_PAL4) ? {4'h0, byte_s1[7:4]} : byte_s1;
	assign direct_rgb = (mode_s1 == MODE_MONO) ? {RGB_W{byte_s1[7]}} : rgb_s1;
	assign pal_we     = valid_s1 && pal_s1 && ({1'b0, idx_s1} < 9'(PAL_DEPTH));

	bru_ram #(
		.WIDTH (RGB_W),
		.DEPTH (PAL_DEPTH)
	) u_palette (
		.clk   (clk),
		.we    (pal_we),
		.waddr (idx_s1[PAL_AW-1:0]),
		.wdata (rgb_s1),
		.re    (emit && use_pal),
		.raddr (rd_idx[PAL_AW-1:0]),
		.rdata (pal_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_BGR24;
			width_q      <= DIM_W'(1);
			height_q     <= DIM_W'(1);
			data_bytes_q <= RBC_W'(3);
			stride_q     <= RBC_W'(4);
			rbc_q        <= '0;
			col_q        <= '0;
			rows_done_q  <= '0;
			gathered_q   <= '0;
			phase_q      <= '0;
			valid_s1     <= 1'b0;
			left_s1      <= '0;
			valid_s2     <= 1'b0;
		end else begin
			if (cfg_hit) begin
				mode_q       <= mode_nx;
				width_q      <= width_nx;
				height_q     <= height_nx;
				data_bytes_q <= data_bytes_nx;
				stride_q     <= (data_bytes_nx + RBC_W'(3)) & ~RBC_W'(3);
				rbc_q        <= '0;
				col_q        <= '0;
				rows_done_q  <= '0;
				gathered_q   <= '0;
				phase_q      <= '0;
			end else if (in_acc && is_data) begin
				if (row_end) begin
					rbc_q       <= '0;
					col_q       <= '0;
					gathered_q  <= '0;
					phase_q     <= '0;
					rows_done_q <= (rows_done_q >= h_last) ? '0 : rows_done_q + COORD_W'(1);
				end else begin
					rbc_q      <= rbc_inc;
					col_q      <= col_q + COORD_W'(n_pix);
					gathered_q <= gathered_nx;
					phase_q    <= phase_nx;
				end
			end

			if (in_acc) begin
				valid_s1 <= 1'b1;
				left_s1  <= is_data ? n_pix : 4'd0;
			end else if (s1_done) begin
				valid_s1 <= 1'b0;
				left_s1  <= '0;
			end else if (emit) begin
				left_s1 <= left_s1 - 4'd1;
			end

			if (emit) begin
				valid_s2 <= 1'b1;
			end else if (pixel.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			pal_s1  <= !is_data;
			mode_s1 <= mode_q;
			byte_s1 <= ib.data_byte;
			rgb_s1  <= is_data ? {ib.data_byte, gathered_q}
				: {ib.palette_red, ib.palette_green, ib.palette_blue};
			idx_s1  <= ib.palette_index;
			col_s1  <= col_q;
			row_s1  <= h_last - rows_done_q;
			top_s1  <= (rows_done_q == h_last);
		end else if (emit) begin
			// next bit (mono) or low nibble (4 bpp) moves to the top
			byte_s1 <= (mode_s1 == MODE_PAL4) ? (byte_s1 << 4) : (byte_s1 << 1);
			col_s1  <= col_s1 + COORD_W'(1);
		end

		if (emit) begin
			pal_s2   <= use_pal;
			black_s2 <= ({1'b0, rd_idx} >= 9'(PAL_DEPTH));
			rgb_s2   <= direct_rgb;
			col_s2   <= col_s1;
			row_s2   <= row_s1;
			lor_s2   <= (left_s1 == 4'd1);
			loi_s2   <= top_s1 && (col_s1 == w_last);
		end
	end

	logic [RGB_W-1:0] out_rgb;
	assign out_rgb = pal_s2 ? (black_s2 ? '0 : pal_rdata) : rgb_s2;

	assign pixel.valid              = valid_s2;
	assign pixel.data.red           = out_rgb[23:16];
	assign pixel.data.green         = out_rgb[15:8];
	assign pixel.data.blue          = out_rgb[7:0];
	assign pixel.data.column        = col_s2;
	assign pixel.data.row           = row_s2;
	assign pixel.data.last_of_run   = lor_s2;
	assign pixel.data.last_of_image = loi_s2;

endmodule
